/* sv/atsc_pkg.sv */
// Shared types and constants for the adaptive time step controller.
// Holds command and status structs, micro-op codes and reset values.
// No dependencies.
package atsc_pkg;

  // Fixed-point constants.
  localparam int unsigned WARMUP_STEPS     = 100;
  localparam logic [63:0] ONE_Q32          = 64'h0000_0001_0000_0000;
  localparam logic [63:0] ONE_Q16          = 64'h0000_0000_0001_0000;
  localparam logic [63:0] HALF_LOG10_2_Q32 = 64'd646456993;
  localparam logic [63:0] LN2_Q32          = 64'd2977044472;

  // Register reset values.
  localparam logic [63:0] RST_END_TIME  = ONE_Q32;
  localparam logic [63:0] RST_INTERVAL  = 64'd429496730;
  localparam logic [31:0] RST_STABILITY = 32'd32768;
  localparam logic [31:0] RST_GROWTH    = 32'd65536;
  localparam logic [31:0] RST_WAVE      = 32'd65536;
  localparam logic [63:0] RST_INIT_STEP = ONE_Q32;
  localparam logic [31:0] RST_TOLERANCE = 32'd1;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    REG_START_TIME  = 3'd0,
    REG_END_TIME    = 3'd1,
    REG_INTERVAL    = 3'd2,
    REG_STABILITY   = 3'd3,
    REG_GROWTH      = 3'd4,
    REG_WAVE        = 3'd5,
    REG_INIT_STEP   = 3'd6,
    REG_TOLERANCE   = 3'd7
  } cfg_idx_e;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_NORMAL = 2'd0,
    ST_OUTPUT = 2'd1,
    ST_END    = 2'd2,
    ST_ABORT  = 2'd3
  } status_e;

  // Datapath micro-operations.
  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_END,
    OP_DEN,
    OP_NXT,
    OP_STEP_SAT,
    OP_WARM_INC,
    OP_W,
    OP_LS,
    OP_LN,
    OP_FACTOR,
    OP_FINAL,
    OP_EMIT
  } op_e;

  // Multiplier operand selection.
  typedef enum logic [2:0] {
    MS_DEN,
    MS_SF,
    MS_WLOG,
    MS_WSTEP,
    MS_LN,
    MS_GF,
    MS_PREV
  } mul_sel_e;

  // Log2 operand selection.
  typedef enum logic [1:0] {
    LS_CNT,
    LS_STEP,
    LS_PREV
  } log_sel_e;

  typedef struct packed {
    op_e      op;
    logic     start_mul;
    mul_sel_e mul_sel;
    logic     start_log;
    log_sel_e log_sel;
    logic     start_div;
  } cmd_t;

  typedef struct packed {
    logic eq_end;
    logic eq_out;
    logic abort;
    logic warm;
    logic grow;
    logic mul_done;
    logic log_done;
    logic div_done;
  } stat_t;

endpackage

/* sv/atsc_mul.sv */
// Sequential 64x64 multiplier built from one 32x32 multiplier.
// Produces the full 128-bit product after start.
// No dependencies.
module atsc_mul (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         start_i,
  input  logic [63:0]  a_i,
  input  logic [63:0]  b_i,
  output logic         done_o,
  output logic [127:0] prod_o
);

  logic         busy_q;
  logic [2:0]   idx_q;
  logic         pv_q;
  logic [1:0]   sh_q;
  logic [63:0]  a_q, b_q, pp_q;
  logic [127:0] acc_q;
  logic [31:0]  opa, opb;
  logic [127:0] addend;

  // Pick the 32-bit halves for the current partial product.
  always_comb begin
    opa    = idx_q[1] ? a_q[63:32] : a_q[31:0];
    opb    = idx_q[0] ? b_q[63:32] : b_q[31:0];
    addend = {64'b0, pp_q} << {sh_q, 5'b0};
  end

  assign done_o = busy_q && (idx_q == 3'd4) && !pv_q;
  assign prod_o = acc_q;

  // Sequencing of the four partial products.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      idx_q  <= '0;
      pv_q   <= 1'b0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      idx_q  <= '0;
      pv_q   <= 1'b0;
    end else if (busy_q) begin
      if (idx_q != 3'd4) begin
        idx_q <= idx_q + 3'd1;
      end
      pv_q <= (idx_q != 3'd4);
      if (done_o) begin
        busy_q <= 1'b0;
      end
    end
  end

  // Registered partial product, then accumulate.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q   <= a_i;
      b_q   <= b_i;
      acc_q <= '0;
    end else if (busy_q) begin
      if (idx_q != 3'd4) begin
        pp_q <= opa * opb;
        sh_q <= {idx_q[1] & idx_q[0], idx_q[1] ^ idx_q[0]};
      end
      if (pv_q) begin
        acc_q <= acc_q + addend;
      end
    end
  end

endmodule

/* sv/atsc_log2.sv */
// Iterative log2 unit: six normalization steps, then 16 squaring steps.
// Result is the integer part in six bits and 16 fraction bits, truncated.
// No dependencies.
module atsc_log2 (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] x_i,
  output logic        done_o,
  output logic [21:0] result_o
);

  logic        busy_q;
  logic [5:0]  cnt_q;
  logic [63:0] x_q;
  logic [5:0]  e_q;
  logic [63:0] sq_q;
  logic [15:0] frac_q;
  logic [6:0]  amt;
  logic        top_zero;
  logic [32:0] sq_t;

  // Binary search for the leading one, widest chunk first.
  always_comb begin
    case (cnt_q)
      6'd0:    amt = 7'd32;
      6'd1:    amt = 7'd16;
      6'd2:    amt = 7'd8;
      6'd3:    amt = 7'd4;
      6'd4:    amt = 7'd2;
      6'd5:    amt = 7'd1;
      default: amt = 7'd1;
    endcase
    top_zero = ((x_q >> (7'd64 - amt)) == 64'd0);
    sq_t     = sq_q[63:31];
  end

  assign done_o   = busy_q && (cnt_q == 6'd38);
  assign result_o = {e_q, frac_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= '0;
    end else if (busy_q) begin
      if (done_o) begin
        busy_q <= 1'b0;
      end else begin
        cnt_q <= cnt_q + 6'd1;
      end
    end
  end

  // The mantissa lives in the upper half of x_q once normalized.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      x_q    <= x_i;
      e_q    <= 6'd63;
      frac_q <= '0;
    end else if (busy_q && !done_o) begin
      if (cnt_q < 6'd6) begin
        if (top_zero) begin
          x_q <= x_q << amt;
          e_q <= e_q - amt[5:0];
        end
      end else if (!cnt_q[0]) begin
        sq_q <= x_q[63:32] * x_q[63:32];
      end else begin
        frac_q     <= {frac_q[14:0], sq_t[32]};
        x_q[63:32] <= sq_t[32] ? sq_t[32:1] : sq_t[31:0];
      end
    end
  end

endmodule

/* sv/atsc_dp.sv */
// Datapath: configuration registers, time state, divider, and result registers.
// Uses atsc_pkg, atsc_mul and atsc_log2; driven by commands from atsc_ctrl.
module atsc_dp (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_index_i,
  input  logic [63:0]        cfg_data_i,
  input  logic [63:0]        stable_step_limit_i,
  input  logic [31:0]        wave_amplitude_i,
  input  logic               abort_request_i,
  input  atsc_pkg::cmd_t     cmd_i,
  output atsc_pkg::stat_t    stat_o,
  output logic [63:0]        new_time_o,
  output logic [63:0]        step_taken_o,
  output logic [1:0]         status_o
);
  import atsc_pkg::*;

  function automatic logic near_eq(logic [63:0] a, logic [63:0] b, logic [31:0] tol);
    logic [63:0] d;
    d = (a > b) ? (a - b) : (b - a);
    return d < {32'b0, tol};
  endfunction

  // Configuration and time state.
  logic [63:0] end_q, intv_q;
  logic [31:0] sf_q, gf_q, wf_q, tol_q;
  logic [63:0] cur_q, nxt_q, prev_q;
  logic [6:0]  cnt_q;

  // Work registers.
  logic [63:0] limit_q;
  logic [31:0] amp_q;
  logic        abort_q;
  logic [63:0] step_q, tmp_q;
  logic [63:0] res_time_q, res_step_q;
  status_e     res_st_q;
  logic [63:0] out_time_q, out_step_q;
  status_e     out_st_q;

  // Divider registers.
  logic        dbusy_q;
  logic [6:0]  dcnt_q;
  logic [63:0] rem_q, quo_q, num_q;

  logic [63:0]  mul_a, mul_b, log_x;
  logic [127:0] prod;
  logic         mul_done, log_done, div_done;
  logic [21:0]  log_res;
  logic [63:0]  diff, sat16, den_v, nt, nxt_new;
  logic [64:0]  nt_sum;
  logic [63:0]  rem_sh, rem_n, gap, fin_step, fin_time;
  logic         take, behind, clip;
  status_e      fin_st;

  atsc_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.start_mul),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .done_o  (mul_done),
    .prod_o  (prod)
  );

  atsc_log2 u_log2 (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (cmd_i.start_log),
    .x_i      (log_x),
    .done_o   (log_done),
    .result_o (log_res)
  );

  // Operand selection for the shared units.
  always_comb begin
    diff = (tmp_q[21:0] > log_res) ? {42'b0, tmp_q[21:0] - log_res} : 64'd0;
    case (cmd_i.mul_sel)
      MS_DEN:   begin mul_a = {32'b0, amp_q};   mul_b = {32'b0, wf_q}; end
      MS_SF:    begin mul_a = limit_q;          mul_b = {32'b0, sf_q}; end
      MS_WLOG:  begin mul_a = {42'b0, log_res}; mul_b = HALF_LOG10_2_Q32; end
      MS_WSTEP: begin mul_a = step_q;           mul_b = tmp_q; end
      MS_LN:    begin mul_a = diff;             mul_b = LN2_Q32; end
      MS_GF:    begin mul_a = {32'b0, gf_q};    mul_b = tmp_q; end
      MS_PREV:  begin mul_a = prev_q;           mul_b = tmp_q; end
      default:  begin mul_a = '0;               mul_b = '0; end
    endcase
    case (cmd_i.log_sel)
      LS_CNT:  log_x = {57'b0, cnt_q};
      LS_STEP: log_x = step_q;
      LS_PREV: log_x = prev_q;
      default: log_x = '0;
    endcase
  end

  // Saturation, output interval and final clipping.
  always_comb begin
    sat16   = (|prod[127:80]) ? '1 : prod[79:16];
    den_v   = (&prod[63:32]) ? '1 : (prod[63:0] + ONE_Q32);
    nt_sum  = {1'b0, cur_q} + {1'b0, quo_q};
    nt      = nt_sum[64] ? '1 : nt_sum[63:0];
    nxt_new = (nt < end_q) ? nt : end_q;
    behind  = nxt_q < cur_q;
    gap     = nxt_q - cur_q;
    clip    = step_q >= gap;
    if (behind) begin
      fin_step = '0;
      fin_time = nxt_q;
      fin_st   = ST_OUTPUT;
    end else begin
      fin_step = clip ? gap : step_q;
      fin_time = cur_q + fin_step;
      fin_st   = clip ? ST_OUTPUT : ST_NORMAL;
    end
  end

  // One quotient bit per cycle; the numerator is shifted out with zeros below.
  always_comb begin
    rem_sh = {rem_q[62:0], num_q[63]};
    take   = rem_q[63] || (rem_sh >= tmp_q);
    rem_n  = take ? (rem_sh - tmp_q) : rem_sh;
  end

  assign div_done = dbusy_q && (dcnt_q == 7'd96);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dbusy_q <= 1'b0;
      dcnt_q  <= '0;
    end else if (cmd_i.start_div) begin
      dbusy_q <= 1'b1;
      dcnt_q  <= '0;
    end else if (dbusy_q) begin
      if (div_done) begin
        dbusy_q <= 1'b0;
      end else begin
        dcnt_q <= dcnt_q + 7'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start_div) begin
      rem_q <= '0;
      quo_q <= '0;
      num_q <= intv_q;
    end else if (dbusy_q && !div_done) begin
      rem_q <= rem_n;
      quo_q <= {quo_q[62:0], take};
      num_q <= num_q << 1;
    end
  end

  // Configuration writes and time state updates.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      end_q  <= RST_END_TIME;
      intv_q <= RST_INTERVAL;
      sf_q   <= RST_STABILITY;
      gf_q   <= RST_GROWTH;
      wf_q   <= RST_WAVE;
      tol_q  <= RST_TOLERANCE;
      cur_q  <= '0;
      nxt_q  <= '0;
      prev_q <= RST_INIT_STEP;
      cnt_q  <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_index_i))
          REG_START_TIME: begin
            cur_q <= cfg_data_i;
            nxt_q <= cfg_data_i;
          end
          REG_END_TIME:  end_q  <= cfg_data_i;
          REG_INTERVAL:  intv_q <= cfg_data_i;
          REG_STABILITY: sf_q   <= cfg_data_i[31:0];
          REG_GROWTH:    gf_q   <= cfg_data_i[31:0];
          REG_WAVE:      wf_q   <= cfg_data_i[31:0];
          REG_INIT_STEP: prev_q <= cfg_data_i;
          REG_TOLERANCE: tol_q  <= cfg_data_i[31:0];
          default: ;
        endcase
      end
      case (cmd_i.op)
        OP_NXT:      nxt_q <= nxt_new;
        OP_WARM_INC: cnt_q <= cnt_q + 7'd1;
        OP_FINAL: begin
          cur_q  <= fin_time;
          prev_q <= fin_step;
        end
        default: ;
      endcase
    end
  end

  // Work and result registers.
  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      OP_LOAD: begin
        limit_q <= stable_step_limit_i;
        amp_q   <= wave_amplitude_i;
        abort_q <= abort_request_i;
      end
      OP_END: begin
        res_time_q <= cur_q;
        res_step_q <= '0;
        res_st_q   <= ST_END;
      end
      OP_DEN: tmp_q <= den_v;
      OP_NXT: begin
        res_time_q <= cur_q;
        res_step_q <= '0;
        res_st_q   <= ST_ABORT;
      end
      OP_STEP_SAT: step_q <= sat16;
      OP_W:        tmp_q  <= prod[95:32];
      OP_LS:       tmp_q  <= {42'b0, log_res};
      OP_LN:       tmp_q  <= prod[95:32];
      OP_FACTOR:   tmp_q  <= prod[79:16] + ONE_Q16;
      OP_FINAL: begin
        res_time_q <= fin_time;
        res_step_q <= fin_step;
        res_st_q   <= fin_st;
      end
      OP_EMIT: begin
        out_time_q <= res_time_q;
        out_step_q <= res_step_q;
        out_st_q   <= res_st_q;
      end
      default: ;
    endcase
  end

  always_comb begin
    stat_o.eq_end   = near_eq(cur_q, end_q, tol_q);
    stat_o.eq_out   = near_eq(cur_q, nxt_q, tol_q);
    stat_o.abort    = abort_q;
    stat_o.warm     = cnt_q < 7'(WARMUP_STEPS);
    stat_o.grow     = (prev_q != 64'd0) && (step_q > prev_q);
    stat_o.mul_done = mul_done;
    stat_o.log_done = log_done;
    stat_o.div_done = div_done;
  end

  assign new_time_o   = out_time_q;
  assign step_taken_o = out_step_q;
  assign status_o     = out_st_q;

endmodule

/* sv/atsc_ctrl.sv */
// Controller state machine: sequences the datapath units for one item.
// Uses atsc_pkg; talks to atsc_dp only through cmd_t and stat_t.
module atsc_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  input  atsc_pkg::stat_t stat_i,
  output atsc_pkg::cmd_t  cmd_o
);
  import atsc_pkg::*;

  typedef enum logic [23:0] {
    S_IDLE     = 24'h000001,
    S_CHECK    = 24'h000002,
    S_DEN_MUL  = 24'h000004,
    S_DIV_GO   = 24'h000008,
    S_DIV      = 24'h000010,
    S_SF_GO    = 24'h000020,
    S_SF_MUL   = 24'h000040,
    S_WARM_INC = 24'h000080,
    S_WLOG_GO  = 24'h000100,
    S_WLOG     = 24'h000200,
    S_WMUL     = 24'h000400,
    S_WSTEP_GO = 24'h000800,
    S_WSTEP    = 24'h001000,
    S_GROW_CHK = 24'h002000,
    S_LOGS     = 24'h004000,
    S_LOGP_GO  = 24'h008000,
    S_LOGP     = 24'h010000,
    S_LN_MUL   = 24'h020000,
    S_GF_GO    = 24'h040000,
    S_GF_MUL   = 24'h080000,
    S_PREV_GO  = 24'h100000,
    S_PREV_MUL = 24'h200000,
    S_FIN      = 24'h400000,
    S_EMIT     = 24'h800000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q;
  logic   out_free;
  cmd_t   cmd;

  assign out_free = !out_valid_q || out_ready_i;

  // Next state and command decode.
  always_comb begin
    state_d       = state_q;
    cmd.op        = OP_NONE;
    cmd.start_mul = 1'b0;
    cmd.mul_sel   = MS_SF;
    cmd.start_log = 1'b0;
    cmd.log_sel   = LS_CNT;
    cmd.start_div = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd.op  = OP_LOAD;
          state_d = S_CHECK;
        end
      end
      S_CHECK: begin
        if (stat_i.eq_end) begin
          cmd.op  = OP_END;
          state_d = S_EMIT;
        end else if (stat_i.eq_out) begin
          cmd.start_mul = 1'b1;
          cmd.mul_sel   = MS_DEN;
          state_d       = S_DEN_MUL;
        end else begin
          state_d = S_SF_GO;
        end
      end
      S_DEN_MUL: begin
        cmd.mul_sel = MS_DEN;
        if (stat_i.mul_done) begin
          cmd.op  = OP_DEN;
          state_d = S_DIV_GO;
        end
      end
      S_DIV_GO: begin
        cmd.start_div = 1'b1;
        state_d       = S_DIV;
      end
      S_DIV: begin
        if (stat_i.div_done) begin
          cmd.op  = OP_NXT;
          state_d = stat_i.abort ? S_EMIT : S_SF_GO;
        end
      end
      S_SF_GO: begin
        cmd.start_mul = 1'b1;
        cmd.mul_sel   = MS_SF;
        state_d       = S_SF_MUL;
      end
      S_SF_MUL: begin
        if (stat_i.mul_done) begin
          cmd.op  = OP_STEP_SAT;
          state_d = stat_i.warm ? S_WARM_INC : S_GROW_CHK;
        end
      end
      S_WARM_INC: begin
        cmd.op  = OP_WARM_INC;
        state_d = S_WLOG_GO;
      end
      S_WLOG_GO: begin
        cmd.start_log = 1'b1;
        cmd.log_sel   = LS_CNT;
        state_d       = S_WLOG;
      end
      S_WLOG: begin
        if (stat_i.log_done) begin
          cmd.start_mul = 1'b1;
          cmd.mul_sel   = MS_WLOG;
          state_d       = S_WMUL;
        end
      end
      S_WMUL: begin
        if (stat_i.mul_done) begin
          cmd.op  = OP_W;
          state_d = S_WSTEP_GO;
        end
      end
      S_WSTEP_GO: begin
        cmd.start_mul = 1'b1;
        cmd.mul_sel   = MS_WSTEP;
        state_d       = S_WSTEP;
      end
      S_WSTEP: begin
        if (stat_i.mul_done) begin
          cmd.op  = OP_STEP_SAT;
          state_d = S_GROW_CHK;
        end
      end
      S_GROW_CHK: begin
        if (stat_i.grow) begin
          cmd.start_log = 1'b1;
          cmd.log_sel   = LS_STEP;
          state_d       = S_LOGS;
        end else begin
          cmd.op  = OP_FINAL;
          state_d = S_EMIT;
        end
      end
      S_LOGS: begin
        if (stat_i.log_done) begin
          cmd.op  = OP_LS;
          state_d = S_LOGP_GO;
        end
      end
      S_LOGP_GO: begin
        cmd.start_log = 1'b1;
        cmd.log_sel   = LS_PREV;
        state_d       = S_LOGP;
      end
      S_LOGP: begin
        if (stat_i.log_done) begin
          cmd.start_mul = 1'b1;
          cmd.mul_sel   = MS_LN;
          state_d       = S_LN_MUL;
        end
      end
      S_LN_MUL: begin
        if (stat_i.mul_done) begin
          cmd.op  = OP_LN;
          state_d = S_GF_GO;
        end
      end
      S_GF_GO: begin
        cmd.start_mul = 1'b1;
        cmd.mul_sel   = MS_GF;
        state_d       = S_GF_MUL;
      end
      S_GF_MUL: begin
        if (stat_i.mul_done) begin
          cmd.op  = OP_FACTOR;
          state_d = S_PREV_GO;
        end
      end
      S_PREV_GO: begin
        cmd.start_mul = 1'b1;
        cmd.mul_sel   = MS_PREV;
        state_d       = S_PREV_MUL;
      end
      S_PREV_MUL: begin
        if (stat_i.mul_done) begin
          cmd.op  = OP_STEP_SAT;
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        cmd.op  = OP_FINAL;
        state_d = S_EMIT;
      end
      S_EMIT: begin
        if (out_free) begin
          cmd.op  = OP_EMIT;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // State register and output valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cmd.op == OP_EMIT) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign cmd_o       = cmd;

endmodule

/* sv/adaptive_time_step_controller.sv */
// Adaptive time step controller, top level. Uses atsc_pkg, atsc_ctrl, atsc_dp.
// An item that reaches the end time is done soonest, a plain step takes longer, and
// an output point in warm-up with growth damping takes longest; the bit-serial
// divider, the log2 unit and the multiplier set the time it takes.
// Throughput: one item at a time; the next is taken once the result is registered.
// Reset: registers load their reset values at once, no clearing pass.
module adaptive_time_step_controller (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_index_i,
  input  logic [63:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [63:0] stable_step_limit_i,
  input  logic [31:0] wave_amplitude_i,
  input  logic        abort_request_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [63:0] new_time_o,
  output logic [63:0] step_taken_o,
  output logic [1:0]  status_o
);
  import atsc_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  atsc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  atsc_dp u_dp (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cfg_we_i            (cfg_we_i),
    .cfg_index_i         (cfg_index_i),
    .cfg_data_i          (cfg_data_i),
    .stable_step_limit_i (stable_step_limit_i),
    .wave_amplitude_i    (wave_amplitude_i),
    .abort_request_i     (abort_request_i),
    .cmd_i               (cmd),
    .stat_o              (stat),
    .new_time_o          (new_time_o),
    .step_taken_o        (step_taken_o),
    .status_o            (status_o)
  );

`ifndef NO_ASSERTIONS
  // Only one item is in work: a transfer in closes the input side.
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input accepted while an item is in work");

  // End and abort results never advance time.
  a_stop_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == ST_END || status_o == ST_ABORT) |-> step_taken_o == 64'd0)
    else $error("nonzero step on end or abort result");

  // A result appears only after an item has been in work.
  a_result_after_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(!in_ready_o))
    else $error("result without an item in work");
`endif

endmodule
